// ----- design/csr_pkg.sv -----
// Shared types and constants for the coin sum reachability block.
package csr_pkg;

  localparam int MAX_SUMS = 1024;
  localparam int ADDR_W   = $clog2(MAX_SUMS);
  localparam int LEN_W    = 11;
  localparam int VALUE_W  = 10;
  localparam int OP_W     = 2;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;
  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_SUMS);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD,
    ST_DRAIN,
    ST_QUERY
  } state_t;

endpackage

// ----- design/coin_sum_reachability.sv -----
// Top level of the coin sum reachability block: one-bit-per-sum map in a synchronous RAM.
//
// A query reads its map entry, then passes the query state and gives a registered result;
// clear writes every map entry in turn, then the strobe; add coin c walks entries c to
// len - 1, then drains. A no-effect add or the unused op reports in the cycle after accept.
// Throughput: one item at a time; busy stays high until the item's work is done.
// Reset (rst_n low, synchronous): active_length returns to 1024 and a clearing pass over
// the whole map runs with busy high; it gives no result. The receiver cannot stall.
module coin_sum_reachability (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [csr_pkg::OP_W-1:0]    in_op,
  input  logic [csr_pkg::VALUE_W-1:0] in_value,
  output logic                        out_valid,
  output logic                        out_reachable,
  input  logic                        cfg_we,
  input  logic [csr_pkg::LEN_W-1:0]   cfg_wdata
);

  // Map RAM: one bit per sum, one write port, one registered read port.
  logic reach_mem [csr_pkg::MAX_SUMS];

  csr_pkg::state_t state_r, state_nxt;

  logic [csr_pkg::LEN_W-1:0]  active_length_r;
  logic [csr_pkg::ADDR_W-1:0] idx_r, idx_nxt;        // walk / sweep position
  logic [csr_pkg::ADDR_W-1:0] coin_r, coin_nxt;
  logic                       report_r, report_nxt;  // clear sweep owes a result
  logic                       q_in_range_r, q_in_range_nxt;
  logic                       wr_pend_r, wr_pend_nxt;
  logic [csr_pkg::ADDR_W-1:0] wr_addr_r, wr_addr_nxt;
  logic                       fwd_r, fwd_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_reachable_r, out_reachable_nxt;

  logic                       rd_data_r;
  logic                       rd_eff;
  logic [csr_pkg::ADDR_W-1:0] rd_addr;
  logic                       mem_we;
  logic [csr_pkg::ADDR_W-1:0] mem_wa;
  logic                       mem_wd;

  logic [csr_pkg::LEN_W-1:0]  len;
  logic [csr_pkg::LEN_W-1:0]  len_last;
  logic                       accept;
  logic                       value_in_range;

  // Clamp the live length to the map size.
  assign len      = (active_length_r > csr_pkg::LEN_MAX) ? csr_pkg::LEN_MAX : active_length_r;
  assign len_last = len - csr_pkg::LEN_W'(1);

  assign busy           = (state_r != csr_pkg::ST_IDLE);
  assign accept         = start && !busy;
  assign value_in_range = ({1'b0, in_value} < len);

  // Read data with the same-cycle write folded in (coin of one reads what it just set).
  assign rd_eff = rd_data_r | fwd_r;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_length_r <= csr_pkg::LEN_RESET;
    end else if (cfg_we) begin
      active_length_r <= cfg_wdata;
    end
  end

  // RAM: write-first is not needed, the forward path covers the overlap.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      reach_mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= reach_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= csr_pkg::ST_CLEAR;
      idx_r       <= '0;
      report_r    <= 1'b0;
      wr_pend_r   <= 1'b0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      report_r    <= report_nxt;
      wr_pend_r   <= wr_pend_nxt;
      fwd_r       <= fwd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    coin_r          <= coin_nxt;
    q_in_range_r    <= q_in_range_nxt;
    wr_addr_r       <= wr_addr_nxt;
    out_reachable_r <= out_reachable_nxt;
  end

  always_comb begin
    state_nxt         = state_r;
    idx_nxt           = idx_r;
    coin_nxt          = coin_r;
    report_nxt        = report_r;
    q_in_range_nxt    = q_in_range_r;
    wr_pend_nxt       = 1'b0;
    wr_addr_nxt       = wr_addr_r;
    fwd_nxt           = 1'b0;
    out_valid_nxt     = 1'b0;
    out_reachable_nxt = 1'b0;
    rd_addr           = in_value[csr_pkg::ADDR_W-1:0];
    mem_we            = 1'b0;
    mem_wa            = wr_addr_r;
    mem_wd            = 1'b1;

    case (state_r)
      csr_pkg::ST_CLEAR: begin
        // Sweep the map: set entry zero, drop every other entry.
        mem_we  = 1'b1;
        mem_wa  = idx_r;
        mem_wd  = (idx_r == '0);
        idx_nxt = idx_r + csr_pkg::ADDR_W'(1);
        if (idx_r == csr_pkg::ADDR_W'(csr_pkg::MAX_SUMS - 1)) begin
          state_nxt     = csr_pkg::ST_IDLE;
          out_valid_nxt = report_r;
          report_nxt    = 1'b0;
        end
      end

      csr_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_op)
            csr_pkg::OP_CLEAR: begin
              state_nxt  = csr_pkg::ST_CLEAR;
              idx_nxt    = '0;
              report_nxt = 1'b1;
            end
            csr_pkg::OP_ADD: begin
              if (in_value != '0 && value_in_range) begin
                state_nxt = csr_pkg::ST_ADD;
                coin_nxt  = in_value[csr_pkg::ADDR_W-1:0];
                idx_nxt   = in_value[csr_pkg::ADDR_W-1:0];
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            csr_pkg::OP_QUERY: begin
              state_nxt      = csr_pkg::ST_QUERY;
              q_in_range_nxt = value_in_range;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      csr_pkg::ST_ADD: begin
        // Read entry idx - coin now, write entry idx in the next cycle if it was set.
        rd_addr     = idx_r - coin_r;
        mem_we      = wr_pend_r && rd_eff;
        wr_pend_nxt = 1'b1;
        wr_addr_nxt = idx_r;
        fwd_nxt     = mem_we && (wr_addr_r == rd_addr);
        idx_nxt     = idx_r + csr_pkg::ADDR_W'(1);
        if ({1'b0, idx_r} == len_last) begin
          state_nxt = csr_pkg::ST_DRAIN;
        end
      end

      csr_pkg::ST_DRAIN: begin
        // Retire the last pending write, then report.
        mem_we        = wr_pend_r && rd_eff;
        state_nxt     = csr_pkg::ST_IDLE;
        out_valid_nxt = 1'b1;
      end

      csr_pkg::ST_QUERY: begin
        state_nxt         = csr_pkg::ST_IDLE;
        out_valid_nxt     = 1'b1;
        out_reachable_nxt = rd_data_r && q_in_range_r;
      end

      default: begin
        state_nxt = csr_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_reachable = out_reachable_r;

`ifndef SYNTHESIS
  // Only the clear sweep may write a zero into the map.
  assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r != csr_pkg::ST_CLEAR) |-> mem_wd)
    else $error("map write of zero outside the clear sweep");

  // A query that is taken always reports after its query state.
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == csr_pkg::OP_QUERY) |=> ##1 out_valid)
    else $error("query result missing");

  // Forwarded data only ever feeds the coin walk.
  assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> (state_r == csr_pkg::ST_ADD || state_r == csr_pkg::ST_DRAIN))
    else $error("forward flag outside the coin walk");

  // Non-query results never claim a reachable sum.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(state_r) != csr_pkg::ST_QUERY) |-> !out_reachable)
    else $error("reachable set on a non-query result");

  // No result while the walk still has a write pending.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == csr_pkg::ST_ADD) |-> !out_valid_nxt)
    else $error("result issued during coin walk");
`endif

endmodule
